[design/fisheye_to_rectilinear_remap_assert.svh]
// Assertion macros for the fisheye remap checker.
// Both expect clk and rst_n in scope at the point of use.
`ifndef FISHEYE_TO_RECTILINEAR_REMAP_ASSERT_SVH
`define FISHEYE_TO_RECTILINEAR_REMAP_ASSERT_SVH

// same-cycle implication
`define FTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ftr_pkg.sv]
// Shared types, constants and helper functions for the fisheye remap.
// No dependencies; used by every cell and the top level.
`default_nettype none

package ftr_pkg;

  localparam int CORDIC_STEPS = 60;
  localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90_FDAA_2216_8C23;
  localparam logic [63:0] HALF_PI_Q60    = 64'h1921_FB54_442D_1846;
  localparam logic [31:0] PI_Q29         = 32'd1686629713;

  localparam logic [7:0] CFG_FOCAL = 8'd0;
  localparam logic [7:0] CFG_MODE  = 8'd1;
  localparam logic [31:0] FOCAL_RESET = 32'd8589935;

  typedef enum logic [1:0] {
    MODE_EQUIDIST   = 2'd0,
    MODE_EQUISOLID  = 2'd1,
    MODE_STEREO     = 2'd2,
    MODE_EQUIDIST_B = 2'd3
  } mode_t;

  typedef logic [63:0] atan_tab_t [CORDIC_STEPS];

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t   tab;
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    tab[0] = QUARTER_PI_Q60;
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      acc = '0;
      for (int k = 0; k < 64; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      tab[i] = acc >> 2;
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] nsh;
    logic [31:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [95:0] dvd;
    logic [31:0] d;
    logic [63:0] q;
    logic        ovf;
  } div_t;

  typedef struct packed {
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] z;
  } cordic_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] f;
    mode_t       mode;
    logic [31:0] rad;
    logic        asin_ovf;
    logic [30:0] a;
    logic        eq_flag;
    logic [31:0] eq_angle;
    logic [63:0] eq_theta;
    logic        flag;
    logic [31:0] angle;
    logic        cvpos;
    logic        sat_q;
    logic [63:0] px;
    logic [63:0] py;
    logic [63:0] ry;
    logic [31:0] fracx;
  } side_t;

  // min(floor(radial * a / rad), 2^31) from its split parts
  function automatic logic [31:0] comp_mag(logic [31:0] a, logic sat, logic [63:0] p,
                                           logic [31:0] frac);
    logic [63:0] s;
    s = p + {32'b0, frac};
    if (a == '0) return '0;
    if (sat) return 32'h8000_0000;
    return (s > 64'h8000_0000) ? 32'h8000_0000 : s[31:0];
  endfunction

  function automatic logic [31:0] sgn_out(logic [31:0] m, logic neg);
    if (neg) return 32'(~m + 32'd1);
    return (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
  endfunction

endpackage

`default_nettype wire

[design/ftr_sqrt_cell.sv]
// One cell of the integer square root chain: two radicand bits per cell.
// Depends on ftr_pkg.
`default_nettype none

module ftr_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ftr_pkg::sqrt_t in_d,
  input  ftr_pkg::side_t in_side,
  output logic          out_valid,
  output ftr_pkg::sqrt_t out_d,
  output ftr_pkg::side_t out_side
);

  logic           valid_r;
  ftr_pkg::sqrt_t d_r, d_nxt;
  ftr_pkg::side_t side_r;
  logic [35:0]    r2, trial;
  logic           ge;

  always_comb begin
    r2    = {in_d.rem, in_d.nsh[63:62]};
    trial = {2'b00, in_d.res, 2'b01};
    ge    = (r2 >= trial);
    d_nxt.rem = ge ? 34'(r2 - trial) : r2[33:0];
    d_nxt.nsh = {in_d.nsh[61:0], 2'b00};
    d_nxt.res = {in_d.res[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

[design/ftr_div_cell.sv]
// One cell of a restoring long division chain: one quotient bit per cell.
// Depends on ftr_pkg.
`default_nettype none

module ftr_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  ftr_pkg::div_t  in_d,
  input  ftr_pkg::side_t in_side,
  output logic          out_valid,
  output ftr_pkg::div_t  out_d,
  output ftr_pkg::side_t out_side
);

  logic           valid_r;
  ftr_pkg::div_t  d_r, d_nxt;
  ftr_pkg::side_t side_r;
  logic [32:0]    r2;
  logic           ge;

  always_comb begin
    r2 = {in_d.rem, in_d.dvd[95]};
    ge = (r2 >= {1'b0, in_d.d});
    d_nxt.rem = ge ? 32'(r2 - {1'b0, in_d.d}) : r2[31:0];
    d_nxt.dvd = {in_d.dvd[94:0], 1'b0};
    d_nxt.d   = in_d.d;
    d_nxt.q   = {in_d.q[62:0], ge};
    d_nxt.ovf = in_d.ovf | in_d.q[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

[design/ftr_cordic_cell.sv]
// One CORDIC iteration, vectoring or rotation, at a fixed step index.
// Depends on ftr_pkg (arctangent table).
`default_nettype none

module ftr_cordic_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            rot,
  input  logic [5:0]      step,
  input  logic            in_valid,
  input  ftr_pkg::cordic_t in_d,
  input  ftr_pkg::side_t   in_side,
  output logic            out_valid,
  output ftr_pkg::cordic_t out_d,
  output ftr_pkg::side_t   out_side
);

  logic             valid_r;
  ftr_pkg::cordic_t d_r, d_nxt;
  ftr_pkg::side_t   side_r;
  logic signed [63:0] dx, dy, t;
  logic             s;

  always_comb begin
    dx = in_d.vy >>> step;
    dy = in_d.vx >>> step;
    t  = $signed(ftr_pkg::ATAN_TAB[step]);
    s  = rot ? in_d.z[63] : (in_d.vy > 64'sd0);
    if (s) begin
      d_nxt.vx = in_d.vx + dx;
      d_nxt.vy = in_d.vy - dy;
      d_nxt.z  = in_d.z + t;
    end else begin
      d_nxt.vx = in_d.vx - dx;
      d_nxt.vy = in_d.vy + dy;
      d_nxt.z  = in_d.z - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

[design/fisheye_to_rectilinear_remap.sv]
// Fisheye to rectilinear remap: top level, chains of sqrt, divide and CORDIC cells.
// Depends on ftr_pkg, ftr_sqrt_cell, ftr_div_cell, ftr_cordic_cell.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/tready    | tdata: sensor_x, sensor_y
//  out_    | out | out_tvalid/tready   | tdata: rect_x, rect_y, field_angle; tuser: out_of_field
//  cfg_    | in  | cfg_valid/ready     | cfg_index, cfg_data
//
// One point accepted per clock unless the chain stalls; each point passes through the cell chains
// (two 32-cell roots, divides of 92, 63, 64 and 2x32 cells, two 60-cell CORDICs).
// rst_n is synchronous; it clears the valids and the output buffer count and resets focal and mode.
// The whole chain stalls only when the two-entry output buffer is full and not read.
`default_nettype none

module fisheye_to_rectilinear_remap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] sensor_x, [63:32] sensor_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] rect_x, [63:32] rect_y, [95:64] field_angle
  output logic        out_tuser,  // [0] out_of_field
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic            en;
  logic [31:0]     focal_r;
  ftr_pkg::mode_t  mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= ftr_pkg::FOCAL_RESET;
      mode_r  <= ftr_pkg::MODE_EQUIDIST;
    end else if (cfg_valid) begin
      if (cfg_index == ftr_pkg::CFG_FOCAL) focal_r <= cfg_data;
      else if (cfg_index == ftr_pkg::CFG_MODE) mode_r <= ftr_pkg::mode_t'(cfg_data[1:0]);
    end
  end

  // input capture
  logic           p0_v_r;
  ftr_pkg::side_t p0_s_r, p0_s_nxt;

  always_comb begin
    p0_s_nxt      = '0;
    p0_s_nxt.negx = in_tdata[31];
    p0_s_nxt.negy = in_tdata[63];
    p0_s_nxt.ax   = in_tdata[31] ? 32'(~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
    p0_s_nxt.ay   = in_tdata[63] ? 32'(~in_tdata[63:32] + 32'd1) : in_tdata[63:32];
    p0_s_nxt.f    = (focal_r == '0) ? 32'd1 : focal_r;
    p0_s_nxt.mode = mode_r;
  end

  // squares, then sum
  logic           p1_v_r, p2_v_r;
  ftr_pkg::side_t p1_s_r, p2_s_r;
  logic [63:0]    p1_sqx_r, p1_sqy_r, p2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_tvalid;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_s_r   <= p0_s_nxt;
      p1_s_r   <= p0_s_r;
      p1_sqx_r <= 64'(p0_s_r.ax) * 64'(p0_s_r.ax);
      p1_sqy_r <= 64'(p0_s_r.ay) * 64'(p0_s_r.ay);
      p2_s_r   <= p1_s_r;
      p2_n_r   <= p1_sqx_r + p1_sqy_r;
    end
  end

  // radius root
  logic           sq1_v [33];
  ftr_pkg::sqrt_t sq1_d [33];
  ftr_pkg::side_t sq1_s [33];

  assign sq1_v[0] = p2_v_r;
  assign sq1_d[0] = '{rem: '0, nsh: p2_n_r, res: '0};
  assign sq1_s[0] = p2_s_r;

  for (genvar i = 0; i < 32; i++) begin : g_sq1
    ftr_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(sq1_v[i]), .in_d(sq1_d[i]), .in_side(sq1_s[i]),
      .out_valid(sq1_v[i+1]), .out_d(sq1_d[i+1]), .out_side(sq1_s[i+1])
    );
  end

  // rad * 2^60 / f
  logic           dv1_v [93];
  ftr_pkg::div_t  dv1_d [93];
  ftr_pkg::side_t dv1_s [93];

  always_comb begin
    dv1_s[0]     = sq1_s[32];
    dv1_s[0].rad = sq1_d[32].res;
    dv1_d[0]     = '{rem: '0, dvd: {sq1_d[32].res, 64'b0}, d: sq1_s[32].f, q: '0, ovf: 1'b0};
  end
  assign dv1_v[0] = sq1_v[32];

  for (genvar i = 0; i < 92; i++) begin : g_dv1
    ftr_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(dv1_v[i]), .in_d(dv1_d[i]), .in_side(dv1_s[i]),
      .out_valid(dv1_v[i+1]), .out_d(dv1_d[i+1]), .out_side(dv1_s[i+1])
    );
  end

  // equidistant results, asin argument, then a^2
  logic           p4_v_r, p5_v_r;
  ftr_pkg::side_t p4_s_r, p4_s_nxt, p5_s_r;
  logic [61:0]    p5_a2_r;

  always_comb begin
    p4_s_nxt          = dv1_s[92];
    p4_s_nxt.eq_theta = dv1_d[92].q;
    p4_s_nxt.eq_flag  = dv1_d[92].ovf | (dv1_d[92].q >= ftr_pkg::HALF_PI_Q60);
    p4_s_nxt.eq_angle = (dv1_d[92].ovf | dv1_d[92].q[63]) ? 32'hFFFF_FFFF
                                                            : dv1_d[92].q[62:31];
    p4_s_nxt.asin_ovf = ({1'b0, dv1_s[92].rad} > {dv1_s[92].f, 1'b0});
    p4_s_nxt.a        = dv1_d[92].q[61:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r <= dv1_v[92];
      p5_v_r <= p4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_s_r  <= p4_s_nxt;
      p5_s_r  <= p4_s_r;
      p5_a2_r <= 62'(p4_s_r.a) * 62'(p4_s_r.a);
    end
  end

  // c = sqrt(2^60 - a^2)
  logic           sq2_v [33];
  ftr_pkg::sqrt_t sq2_d [33];
  ftr_pkg::side_t sq2_s [33];

  assign sq2_v[0] = p5_v_r;
  assign sq2_d[0] = '{rem: '0, nsh: (64'd1 << 60) - {2'b00, p5_a2_r}, res: '0};
  assign sq2_s[0] = p5_s_r;

  for (genvar i = 0; i < 32; i++) begin : g_sq2
    ftr_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(sq2_v[i]), .in_d(sq2_d[i]), .in_side(sq2_s[i]),
      .out_valid(sq2_v[i+1]), .out_d(sq2_d[i+1]), .out_side(sq2_s[i+1])
    );
  end

  // vectoring CORDIC
  logic             vc_v [61];
  ftr_pkg::cordic_t vc_d [61];
  ftr_pkg::side_t   vc_s [61];

  always_comb begin
    vc_d[0].z = '0;
    unique case (sq2_s[32].mode)
      ftr_pkg::MODE_EQUISOLID: begin
        vc_d[0].vx = {12'b0, sq2_d[32].res, 20'b0};
        vc_d[0].vy = {13'b0, sq2_s[32].a, 20'b0};
      end
      ftr_pkg::MODE_STEREO: begin
        vc_d[0].vx = {11'b0, sq2_s[32].f, 21'b0};
        vc_d[0].vy = {12'b0, sq2_s[32].rad, 20'b0};
      end
      default: begin
        vc_d[0].vx = '0;
        vc_d[0].vy = '0;
      end
    endcase
  end
  assign vc_v[0] = sq2_v[32];
  assign vc_s[0] = sq2_s[32];

  for (genvar i = 0; i < 60; i++) begin : g_vc
    ftr_cordic_cell u_cell (
      .clk, .rst_n, .en, .rot(1'b0), .step(6'(i)),
      .in_valid(vc_v[i]), .in_d(vc_d[i]), .in_side(vc_s[i]),
      .out_valid(vc_v[i+1]), .out_d(vc_d[i+1]), .out_side(vc_s[i+1])
    );
  end

  // select theta, flag, field angle per lens model
  logic           p7_v_r;
  ftr_pkg::side_t p7_s_r, p7_s_nxt;
  logic [63:0]    p7_theta_r, p7_theta_nxt;
  logic [63:0]    phi, theta_v;
  logic           flag_v;

  always_comb begin
    phi      = vc_d[60].z[63] ? 64'd0 : vc_d[60].z;
    theta_v  = {phi[62:0], 1'b0};
    flag_v   = ($signed(theta_v) >= $signed(ftr_pkg::HALF_PI_Q60));
    p7_s_nxt = vc_s[60];
    unique case (vc_s[60].mode)
      ftr_pkg::MODE_EQUISOLID: begin
        if (vc_s[60].asin_ovf) begin
          p7_theta_nxt   = '0;
          p7_s_nxt.flag  = 1'b1;
          p7_s_nxt.angle = ftr_pkg::PI_Q29;
        end else begin
          p7_theta_nxt   = theta_v;
          p7_s_nxt.flag  = flag_v;
          p7_s_nxt.angle = theta_v[62:31];
        end
      end
      ftr_pkg::MODE_STEREO: begin
        p7_theta_nxt   = theta_v;
        p7_s_nxt.flag  = flag_v;
        p7_s_nxt.angle = theta_v[62:31];
      end
      default: begin
        p7_theta_nxt   = vc_s[60].eq_theta;
        p7_s_nxt.flag  = vc_s[60].eq_flag;
        p7_s_nxt.angle = vc_s[60].eq_angle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p7_v_r <= 1'b0;
    end else if (en) begin
      p7_v_r <= vc_v[60];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p7_s_r     <= p7_s_nxt;
      p7_theta_r <= p7_theta_nxt;
    end
  end

  // rotation CORDIC
  logic             rc_v [61];
  ftr_pkg::cordic_t rc_d [61];
  ftr_pkg::side_t   rc_s [61];

  assign rc_v[0] = p7_v_r;
  assign rc_d[0] = '{vx: 64'sd1 <<< 30, vy: '0, z: p7_theta_r};
  assign rc_s[0] = p7_s_r;

  for (genvar i = 0; i < 60; i++) begin : g_rc
    ftr_cordic_cell u_cell (
      .clk, .rst_n, .en, .rot(1'b1), .step(6'(i)),
      .in_valid(rc_v[i]), .in_d(rc_d[i]), .in_side(rc_s[i]),
      .out_valid(rc_v[i+1]), .out_d(rc_d[i+1]), .out_side(rc_s[i+1])
    );
  end

  // f * sin
  logic           p8_v_r;
  ftr_pkg::side_t p8_s_r, p8_s_nxt;
  logic [62:0]    p8_prod_r;
  logic [31:0]    p8_cv_r;
  logic [30:0]    sv_c;

  always_comb begin
    sv_c           = rc_d[60].vy[63] ? 31'd0 : rc_d[60].vy[30:0];
    p8_s_nxt       = rc_s[60];
    p8_s_nxt.cvpos = !rc_d[60].vx[63] && (rc_d[60].vx != 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_v_r <= 1'b0;
    end else if (en) begin
      p8_v_r <= rc_v[60];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p8_s_r    <= p8_s_nxt;
      p8_prod_r <= 63'(rc_s[60].f) * 63'(sv_c);
      p8_cv_r   <= rc_d[60].vx[31:0];
    end
  end

  // f * sin / cos
  logic           dv2_v [64];
  ftr_pkg::div_t  dv2_d [64];
  ftr_pkg::side_t dv2_s [64];

  assign dv2_v[0] = p8_v_r;
  assign dv2_d[0] = '{rem: '0, dvd: {p8_prod_r, 33'b0}, d: p8_cv_r, q: '0, ovf: 1'b0};
  assign dv2_s[0] = p8_s_r;

  for (genvar i = 0; i < 63; i++) begin : g_dv2
    ftr_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(dv2_v[i]), .in_d(dv2_d[i]), .in_side(dv2_s[i]),
      .out_valid(dv2_v[i+1]), .out_d(dv2_d[i+1]), .out_side(dv2_s[i+1])
    );
  end

  // radial / rad
  logic           dv3_v [65];
  ftr_pkg::div_t  dv3_d [65];
  ftr_pkg::side_t dv3_s [65];
  logic [63:0]    radial;

  always_comb begin
    radial   = dv2_s[63].cvpos ? {6'b0, dv2_d[63].q[63:6]} : 64'h8000_0000_0000_0000;
    dv3_d[0] = '{rem: '0, dvd: {radial, 32'b0}, d: dv2_s[63].rad, q: '0, ovf: 1'b0};
  end
  assign dv3_v[0] = dv2_v[63];
  assign dv3_s[0] = dv2_s[63];

  for (genvar i = 0; i < 64; i++) begin : g_dv3
    ftr_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(dv3_v[i]), .in_d(dv3_d[i]), .in_side(dv3_s[i]),
      .out_valid(dv3_v[i+1]), .out_d(dv3_d[i+1]), .out_side(dv3_s[i+1])
    );
  end

  // whole and fractional products for each component
  logic           p10_v_r;
  ftr_pkg::side_t p10_s_r, p10_s_nxt;
  logic [63:0]    p10_rx_r;

  always_comb begin
    p10_s_nxt       = dv3_s[64];
    p10_s_nxt.sat_q = dv3_d[64].ovf | (dv3_d[64].q[63:32] != '0);
    p10_s_nxt.px    = 64'(dv3_d[64].q[31:0]) * 64'(dv3_s[64].ax);
    p10_s_nxt.py    = 64'(dv3_d[64].q[31:0]) * 64'(dv3_s[64].ay);
    p10_s_nxt.ry    = 64'(dv3_d[64].rem) * 64'(dv3_s[64].ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p10_v_r <= 1'b0;
    end else if (en) begin
      p10_v_r <= dv3_v[64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p10_s_r  <= p10_s_nxt;
      p10_rx_r <= 64'(dv3_d[64].rem) * 64'(dv3_s[64].ax);
    end
  end

  // rem * |x| / rad, then rem * |y| / rad
  logic           dx_v [33];
  ftr_pkg::div_t  dx_d [33];
  ftr_pkg::side_t dx_s [33];
  logic           dy_v [33];
  ftr_pkg::div_t  dy_d [33];
  ftr_pkg::side_t dy_s [33];

  assign dx_v[0] = p10_v_r;
  assign dx_d[0] = '{rem: p10_rx_r[63:32], dvd: {p10_rx_r[31:0], 64'b0},
                     d: p10_s_r.rad, q: '0, ovf: 1'b0};
  assign dx_s[0] = p10_s_r;

  for (genvar i = 0; i < 32; i++) begin : g_dx
    ftr_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(dx_v[i]), .in_d(dx_d[i]), .in_side(dx_s[i]),
      .out_valid(dx_v[i+1]), .out_d(dx_d[i+1]), .out_side(dx_s[i+1])
    );
  end

  always_comb begin
    dy_s[0]       = dx_s[32];
    dy_s[0].fracx = dx_d[32].q[31:0];
    dy_d[0]       = '{rem: dx_s[32].ry[63:32], dvd: {dx_s[32].ry[31:0], 64'b0},
                      d: dx_s[32].rad, q: '0, ovf: 1'b0};
  end
  assign dy_v[0] = dx_v[32];

  for (genvar i = 0; i < 32; i++) begin : g_dy
    ftr_div_cell u_cell (
      .clk, .rst_n, .en,
      .in_valid(dy_v[i]), .in_d(dy_d[i]), .in_side(dy_s[i]),
      .out_valid(dy_v[i+1]), .out_d(dy_d[i+1]), .out_side(dy_s[i+1])
    );
  end

  // result assembly
  ftr_pkg::side_t fs;
  logic           zero_o;
  logic [31:0]    mx, my;
  logic [96:0]    fin_d;
  logic           fin_v;

  always_comb begin
    fs     = dy_s[32];
    zero_o = fs.flag | (fs.rad == '0);
    mx     = ftr_pkg::comp_mag(fs.ax, fs.sat_q, fs.px, fs.fracx);
    my     = ftr_pkg::comp_mag(fs.ay, fs.sat_q, fs.py, dy_d[32].q[31:0]);
    fin_d  = {fs.flag, fs.angle,
              zero_o ? 32'd0 : ftr_pkg::sgn_out(my, fs.negy),
              zero_o ? 32'd0 : ftr_pkg::sgn_out(mx, fs.negx)};
    fin_v  = dy_v[32];
  end

  // two-entry output buffer
  logic [96:0] buf0_r, buf1_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign en         = (cnt_r != 2'd2) || out_tready;
  assign in_tready  = en;
  assign push       = fin_v && en;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf0_r[95:0];
  assign out_tuser  = buf0_r[96];
  assign cnt_nxt    = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      buf0_r <= (cnt_r == 2'd2) ? buf1_r : fin_d;
    end else if (push && cnt_r == 2'd0) begin
      buf0_r <= fin_d;
    end
    if (push && ((cnt_r == 2'd1 && !pop) || (cnt_r == 2'd2 && pop))) begin
      buf1_r <= fin_d;
    end
  end

endmodule

`default_nettype wire

[design/ftr_port_check.sv]
// Port-level checker for the fisheye remap, bound to the top level.
// Depends on fisheye_to_rectilinear_remap_assert.svh.
`default_nettype none

`include "fisheye_to_rectilinear_remap_assert.svh"

module ftr_port_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  `FTR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out transaction dropped")
  `FTR_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out data moved")
  `FTR_ASSERT_NOW(a_flag_zero, out_tvalid && out_tuser, out_tdata[63:0] == 64'd0, "rect not zero")
  `FTR_ASSERT_NOW(a_angle_range, out_tvalid && !out_tuser,
                  out_tdata[95:64] <= 32'd843314857, "angle in field too large")

endmodule

bind fisheye_to_rectilinear_remap ftr_port_check u_port_check (.*);

`default_nettype wire
